// ===== rtl/core/swfi_pkg.sv =====
// ============================================================================
// swfi_pkg: shared types and constants of the smoothed windowed frame integrator
// Register indexes, item kinds, the configuration record and the queued item.
// ============================================================================
package swfi_pkg;

    localparam int MAX_FRAME_DEF   = 4096;
    localparam int MAX_AVERAGE_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam int ACC_W      = 48;
    localparam int SAMPLE_W   = 8;
    localparam int COEF_W     = 16;
    localparam int INDEX_W    = 12;
    localparam int FLEN_W     = 13;
    localparam int ALEN_W     = 7;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ENABLE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_LENGTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SHOT_COUNT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TOMO_COUNT     = CFG_IDX_W'(4);

    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic [FLEN_W-1:0]  frame_length;
        logic               smooth_enable;
        logic [ALEN_W-1:0]  average_length;
        logic [COUNT_W-1:0] shot_count;
        logic [COUNT_W-1:0] tomo_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        frame_length:   FLEN_W'(4096),
        smooth_enable:  1'b1,
        average_length: ALEN_W'(1),
        shot_count:     COUNT_W'(0),
        tomo_count:     COUNT_W'(0)
    };

    typedef struct packed {
        logic                     kind;
        logic [INDEX_W-1:0]       coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

endpackage

// ===== rtl/core/swfi_queue.sv =====
// ============================================================================
// swfi_queue: input queue of the frame integrator
// Accepts items from the input channel and holds them until the back end
// takes them, so that either side may stall on its own.
// ============================================================================
module swfi_queue #(
    parameter int DEPTH = swfi_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_stall,
    input  swfi_pkg::item_t push_item,
    output logic           head_valid,
    output swfi_pkg::item_t head_item,
    input  logic           pop
);
    import swfi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_stall = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/swfi_back.sv =====
// ============================================================================
// swfi_back: execution sequencer of the frame integrator
// Loads window coefficients, runs the moving average with a bit-serial
// divider, weights each value, accumulates with saturation and emits the
// frame result through an output register.
// ============================================================================
module swfi_back #(
    parameter int MAX_FRAME   = swfi_pkg::MAX_FRAME_DEF,
    parameter int MAX_AVERAGE = swfi_pkg::MAX_AVERAGE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swfi_pkg::cfg_t                     cfg,
    input  logic                               head_valid,
    input  swfi_pkg::item_t                    head_item,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [swfi_pkg::ACC_W-1:0]  frame_sum,
    output logic                               is_tomo_frame,
    output logic [swfi_pkg::COUNT_W-1:0]       frame_number,
    output logic                               last_frame
);
    import swfi_pkg::*;

    localparam int POS_W  = $clog2(MAX_FRAME);
    localparam int LEN_W  = $clog2(MAX_FRAME + 1);
    localparam int FILL_W = $clog2(MAX_AVERAGE + 1);
    localparam int SLOT_W = (MAX_AVERAGE > 1) ? $clog2(MAX_AVERAGE) : 1;
    localparam int RS_W   = SAMPLE_W + FILL_W;
    localparam int VAL_W  = RS_W + 8;
    localparam int PROD_W = VAL_W + COEF_W;
    localparam int DCNT_W = $clog2(VAL_W + 1);
    localparam int TOT_W  = COUNT_W + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    logic signed [COEF_W-1:0]   coef_mem [MAX_FRAME];
    logic signed [SAMPLE_W-1:0] delay_mem [MAX_AVERAGE];

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic [SLOT_W-1:0]          slot_reg;
    logic [SLOT_W-1:0]          slot_next;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_next;
    logic signed [RS_W-1:0]     rs_reg;
    logic signed [RS_W-1:0]     rs_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic [COUNT_W-1:0]         fc_reg;
    logic [COUNT_W-1:0]         fc_next;
    logic [DCNT_W-1:0]          dcnt_reg;
    logic [DCNT_W-1:0]          dcnt_next;
    logic [VAL_W-1:0]           quo_reg;
    logic [VAL_W-1:0]           quo_next;
    logic [FILL_W-1:0]          rem_reg;
    logic [FILL_W-1:0]          rem_next;
    logic                       neg_reg;
    logic                       neg_next;
    logic signed [VAL_W-1:0]    val_reg;
    logic signed [VAL_W-1:0]    val_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic signed [COEF_W-1:0]   coef_rd_reg;
    logic signed [SAMPLE_W-1:0] dl_rd_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [ACC_W-1:0]    sum_out_reg;
    logic                       tomo_out_reg;
    logic [COUNT_W-1:0]         num_out_reg;
    logic                       last_out_reg;
    logic                       out_load;

    logic [LEN_W-1:0]           len_eff;
    logic [FILL_W-1:0]          avr_eff;
    logic                       frame_end;
    logic                       coef_we;
    logic [POS_W-1:0]           coef_waddr;
    logic                       sample_re;
    logic                       delay_we;
    logic [31:0]                idx32;
    logic signed [SAMPLE_W-1:0] old_smp;
    logic signed [VAL_W-1:0]    num_signed;
    logic [FILL_W:0]            trial;
    logic signed [ACC_W:0]      acc_wide;
    logic signed [ACC_W-1:0]    acc_sat;
    logic [TOT_W-1:0]           total;
    logic                       is_last;
    logic                       out_free;

    assign out_valid     = out_valid_reg;
    assign frame_sum     = sum_out_reg;
    assign is_tomo_frame = tomo_out_reg;
    assign frame_number  = num_out_reg;
    assign last_frame    = last_out_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cfg.frame_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(cfg.frame_length) > 32'(MAX_FRAME))
        begin
            len_eff = LEN_W'(MAX_FRAME);
        end
        else
        begin
            len_eff = LEN_W'(cfg.frame_length);
        end
        if (cfg.average_length == '0)
        begin
            avr_eff = FILL_W'(1);
        end
        else if (32'(cfg.average_length) > 32'(MAX_AVERAGE))
        begin
            avr_eff = FILL_W'(MAX_AVERAGE);
        end
        else
        begin
            avr_eff = FILL_W'(cfg.average_length);
        end
    end

    assign frame_end  = (32'(pos_reg) + 32'd1) >= 32'(len_eff);
    assign idx32      = 32'(head_item.coef_index);
    assign coef_waddr = idx32[POS_W-1:0];
    assign total      = TOT_W'(cfg.shot_count) + TOT_W'(cfg.tomo_count);
    assign is_last    = (total != '0) && (TOT_W'(fc_reg) == total - 1'b1);
    assign old_smp    = (fill_reg >= avr_eff) ? dl_rd_reg : '0;
    assign trial      = {rem_reg, quo_reg[VAL_W-1]};
    assign acc_wide   = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(prod_reg);

    always_comb
    begin
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1])
        begin
            acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                      : {1'b0, {(ACC_W - 1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_wide[ACC_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        rs_next        = rs_reg;
        acc_next       = acc_reg;
        fc_next        = fc_reg;
        dcnt_next      = dcnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        val_next       = val_reg;
        prod_next      = prod_reg;
        num_signed     = '0;
        pop            = 1'b0;
        coef_we        = 1'b0;
        sample_re      = 1'b0;
        delay_we       = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_item.kind == KIND_COEF)
                    begin
                        coef_we = (idx32 < 32'(MAX_FRAME));
                    end
                    else
                    begin
                        sample_re  = 1'b1;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                delay_we = 1'b1;
                rs_next  = rs_reg + RS_W'(smp_reg) - RS_W'(old_smp);
                if (fill_reg < avr_eff)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                if ((32'(slot_reg) + 32'd1) >= 32'(avr_eff))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                num_signed = {rs_next, 8'b0};
                neg_next   = num_signed[VAL_W-1];
                quo_next   = neg_next ? VAL_W'(-num_signed) : VAL_W'(num_signed);
                rem_next   = '0;
                dcnt_next  = DCNT_W'(VAL_W);
                if (cfg.smooth_enable)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    val_next   = VAL_W'(smp_reg) <<< 8;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    val_next   = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                    state_next = ST_MUL;
                end
                else
                begin
                    dcnt_next = dcnt_reg - 1'b1;
                    if (trial >= {1'b0, fill_reg})
                    begin
                        rem_next = FILL_W'(trial - {1'b0, fill_reg});
                        quo_next = {quo_reg[VAL_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[FILL_W-1:0];
                        quo_next = {quo_reg[VAL_W-2:0], 1'b0};
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(val_reg) * PROD_W'(coef_rd_reg);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!frame_end)
                begin
                    acc_next   = acc_sat;
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    fc_next        = is_last ? '0 : fc_reg + 1'b1;
                    acc_next       = '0;
                    pos_next       = '0;
                    slot_next      = '0;
                    fill_next      = '0;
                    rs_next        = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            rs_reg        <= '0;
            acc_reg       <= '0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            rs_reg        <= rs_next;
            acc_reg       <= acc_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dcnt_reg <= dcnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        val_reg  <= val_next;
        prod_reg <= prod_next;
        if (sample_re)
        begin
            smp_reg <= head_item.sample;
        end
        if (out_load)
        begin
            sum_out_reg  <= acc_sat;
            tomo_out_reg <= (fc_reg >= cfg.shot_count);
            num_out_reg  <= fc_reg;
            last_out_reg <= is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= head_item.coef_value;
        end
        if (sample_re)
        begin
            coef_rd_reg <= coef_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (delay_we)
        begin
            delay_mem[slot_reg] <= smp_reg;
        end
        if (sample_re)
        begin
            dl_rd_reg <= delay_mem[slot_reg];
        end
    end

endmodule

// ===== rtl/core/smoothed_windowed_frame_integrator.sv =====
// ============================================================================
// smoothed_windowed_frame_integrator: windowed frame sum of digitizer samples
// Moving-average smoothing, window weighting and saturating accumulation
// over frames, with shot and tomography frame flags on each result.
// ============================================================================
// The input channel carries one item per handshake: either a window
// coefficient load (kind low) or a digitizer sample (kind high). An item is
// taken when in_valid is high and in_stall is low. A four-entry queue sits
// behind the input, so items keep arriving while earlier ones are worked on.
// A sample passes the sum, divide, multiply and accumulate states with
// smoothing on, the divide bound by the bit-serial divider that yields one
// quotient bit per cycle, and skips the divide state with smoothing off.
// The last sample of a frame loads its result in the accumulate state. The
// result waits in an output register while out_stall is high; the sequencer
// holds at the frame end until the register is free, and the queue fills
// and raises in_stall. Reset empties the queue, drops out_valid, loads the
// register defaults and clears the frame state; the coefficient memory and
// delay line keep no reset value. The user must write registers with
// cfg_write, cfg_index and cfg_data only while no item is in flight; the
// block itself does not enforce this.
// ============================================================================
module smoothed_windowed_frame_integrator #(
    parameter int MAX_FRAME   = swfi_pkg::MAX_FRAME_DEF,
    parameter int MAX_AVERAGE = swfi_pkg::MAX_AVERAGE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [swfi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swfi_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [swfi_pkg::INDEX_W-1:0]         coef_index,
    input  logic signed [swfi_pkg::COEF_W-1:0]   coef_value,
    input  logic signed [swfi_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [swfi_pkg::ACC_W-1:0]    frame_sum,
    output logic                                 is_tomo_frame,
    output logic [swfi_pkg::COUNT_W-1:0]         frame_number,
    output logic                                 last_frame
);
    import swfi_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item;
    item_t head_item;
    logic  head_valid;
    logic  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_LENGTH:   cfg_reg.frame_length   <= cfg_data[FLEN_W-1:0];
                REG_SMOOTH_ENABLE:  cfg_reg.smooth_enable  <= cfg_data[0];
                REG_AVERAGE_LENGTH: cfg_reg.average_length <= cfg_data[ALEN_W-1:0];
                REG_SHOT_COUNT:     cfg_reg.shot_count     <= cfg_data[COUNT_W-1:0];
                REG_TOMO_COUNT:     cfg_reg.tomo_count     <= cfg_data[COUNT_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_item = '{
        kind:       kind,
        coef_index: coef_index,
        coef_value: coef_value,
        sample:     sample
    };

    swfi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_item  (in_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    swfi_back #(
        .MAX_FRAME   (MAX_FRAME),
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_sum     (frame_sum),
        .is_tomo_frame (is_tomo_frame),
        .frame_number  (frame_number),
        .last_frame    (last_frame)
    );

endmodule

// ===== rtl/core/swfi_checker.sv =====
// ============================================================================
// swfi_checker: port-level checks of the frame integrator
// Watches the output channel and the reset behaviour of both channels.
// ============================================================================
module swfi_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [swfi_pkg::ACC_W-1:0]    frame_sum,
    input logic                                 is_tomo_frame,
    input logic [swfi_pkg::COUNT_W-1:0]         frame_number,
    input logic                                 last_frame
);
    import swfi_pkg::*;

    logic [COUNT_W-1:0] expect_num_reg;

    // The frame number that the next result must carry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_num_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            expect_num_reg <= last_frame ? '0 : frame_number + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_sum) && $stable(is_tomo_frame)
            && $stable(frame_number) && $stable(last_frame))
        else $error("stalled result changed");

    a_frame_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_number == expect_num_reg)
        else $error("frame number out of sequence");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("channels active during reset");

endmodule

bind smoothed_windowed_frame_integrator swfi_checker u_swfi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_sum     (frame_sum),
    .is_tomo_frame (is_tomo_frame),
    .frame_number  (frame_number),
    .last_frame    (last_frame)
);

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench: self-checking bench of the smoothed windowed frame integrator
// A short directed stimulus table is followed by a coefficient load of the
// leading window positions and random phases of samples and coefficient loads
// under varied register settings. Frame results are compared with the table
// or an in-bench model of the smoothing, window weighting and frame counting.
// ============================================================================
module testbench;
    import swfi_pkg::*;

    localparam int  DRAIN_CYCLES   = 200;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  RANDOM_PHASES  = 15;
    localparam int  PHASE_ITEMS    = 85;
    localparam int  PRELOAD_LEN    = 256;
    localparam int  PLAN_LEN       = 30;
    localparam longint SUM_HI      = 64'sd140737488355327;
    localparam longint SUM_LO      = -SUM_HI - 1;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic                    tomo;
        logic [COUNT_W-1:0]      number;
        logic                    last;
    } frame_res_t;

    typedef enum logic [1:0] {ROW_REG, ROW_COEF, ROW_SAMPLE} row_op_t;

    typedef struct packed {
        row_op_t    op;
        int         addr;
        int         data;
        logic       typed;
        frame_res_t want;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_REG,    REG_FRAME_LENGTH,   1,      1'b0, '{0, 0, 0, 0}},
        '{ROW_COEF,   0,                  16384,  1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  127,    1'b1, '{532676608, 1, 0, 0}},
        '{ROW_SAMPLE, 0,                  -128,   1'b1, '{-536870912, 1, 1, 0}},
        '{ROW_COEF,   0,                  -32768, 1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  -128,   1'b1, '{1073741824, 1, 2, 0}},
        '{ROW_COEF,   0,                  32767,  1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  127,    1'b1, '{1065320704, 1, 3, 0}},
        '{ROW_COEF,   4095,               -21846, 1'b0, '{0, 0, 0, 0}},
        '{ROW_REG,    REG_SHOT_COUNT,     2,      1'b0, '{0, 0, 0, 0}},
        '{ROW_REG,    REG_TOMO_COUNT,     3,      1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  1,      1'b1, '{8388352, 1, 4, 1}},
        '{ROW_SAMPLE, 0,                  0,      1'b0, '{0, 0, 0, 0}},
        '{ROW_REG,    REG_FRAME_LENGTH,   4,      1'b0, '{0, 0, 0, 0}},
        '{ROW_REG,    REG_AVERAGE_LENGTH, 3,      1'b0, '{0, 0, 0, 0}},
        '{ROW_COEF,   1,                  12345,  1'b0, '{0, 0, 0, 0}},
        '{ROW_COEF,   2,                  -20000, 1'b0, '{0, 0, 0, 0}},
        '{ROW_COEF,   3,                  8192,   1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  100,    1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  -50,    1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  127,    1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  -128,   1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  5,      1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  6,      1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  7,      1'b0, '{0, 0, 0, 0}},
        '{ROW_REG,    REG_FRAME_LENGTH,   2,      1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  8,      1'b0, '{0, 0, 0, 0}},
        '{ROW_REG,    REG_SMOOTH_ENABLE,  0,      1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  -128,   1'b0, '{0, 0, 0, 0}},
        '{ROW_SAMPLE, 0,                  127,    1'b0, '{0, 0, 0, 0}}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       kind;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [ACC_W-1:0]    frame_sum;
    logic                       is_tomo_frame;
    logic [COUNT_W-1:0]         frame_number;
    logic                       last_frame;

    // Model copy of the registers and the frame state.
    int     cfg_len    = CFG_RESET.frame_length;
    int     cfg_smooth = CFG_RESET.smooth_enable;
    int     cfg_avg    = CFG_RESET.average_length;
    int     cfg_shot   = CFG_RESET.shot_count;
    int     cfg_tomo   = CFG_RESET.tomo_count;
    logic signed [COEF_W-1:0]   coef_mem  [MAX_FRAME_DEF];
    logic signed [SAMPLE_W-1:0] delay_mem [MAX_AVERAGE_DEF];
    int     run_sum   = 0;
    int     fill      = 0;
    int     pos       = 0;
    longint acc       = 0;
    int     frame_cnt = 0;

    frame_res_t frame_q [$];
    bit  calm         = 1'b0;
    int  errors       = 0;
    int  n_items      = 0;
    int  n_samples    = 0;
    int  n_results    = 0;
    int  n_last       = 0;
    int  n_setups     = 0;
    int  quiet_cycles = 0;

    smoothed_windowed_frame_integrator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .coef_index    (coef_index),
        .coef_value    (coef_value),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_sum     (frame_sum),
        .is_tomo_frame (is_tomo_frame),
        .frame_number  (frame_number),
        .last_frame    (last_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit integrate_item(input logic k, input logic [INDEX_W-1:0] idx,
                                          input logic signed [COEF_W-1:0] cv,
                                          input logic signed [SAMPLE_W-1:0] smp,
                                          output frame_res_t res);
        int     len;
        int     avr;
        int     slot;
        int     val;
        int     total;
        longint next_acc;
        bit     hit_last;
        res = '0;
        if (k == KIND_COEF)
        begin
            coef_mem[idx] = cv;
            return 1'b0;
        end
        len = (cfg_len == 0) ? 1 : ((cfg_len > MAX_FRAME_DEF) ? MAX_FRAME_DEF : cfg_len);
        avr = (cfg_avg == 0) ? 1 : ((cfg_avg > MAX_AVERAGE_DEF) ? MAX_AVERAGE_DEF : cfg_avg);
        slot = pos % avr;
        run_sum = run_sum + smp;
        if (fill < avr)
            fill++;
        else
            run_sum = run_sum - delay_mem[slot];
        delay_mem[slot] = smp;
        if (cfg_smooth != 0)
            val = (run_sum * 256) / ((fill != 0) ? fill : 1);
        else
            val = smp * 256;
        next_acc = acc + longint'(val) * longint'(coef_mem[pos]);
        acc = (next_acc > SUM_HI) ? SUM_HI : ((next_acc < SUM_LO) ? SUM_LO : next_acc);
        if (pos + 1 < len)
        begin
            pos++;
            return 1'b0;
        end
        total = cfg_shot + cfg_tomo;
        hit_last = (total != 0) && (frame_cnt == total - 1);
        res.sum = acc[ACC_W-1:0];
        res.tomo = (frame_cnt >= cfg_shot);
        res.number = frame_cnt[COUNT_W-1:0];
        res.last = hit_last;
        frame_cnt = hit_last ? 0 : ((frame_cnt + 1) & 16'hFFFF);
        pos = 0;
        acc = 0;
        run_sum = 0;
        fill = 0;
        return 1'b1;
    endfunction

    task automatic feed_item(input logic k, input logic [INDEX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] cv,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic typed, input frame_res_t want);
        frame_res_t got;
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        coef_index <= idx;
        coef_value <= cv;
        sample     <= smp;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        n_items++;
        if (k == KIND_SAMPLE)
            n_samples++;
        if (integrate_item(k, idx, cv, smp, got))
            frame_q.push_back(typed ? want : got);
    endtask

    task automatic feed_random_sample();
        logic signed [SAMPLE_W-1:0] smp;
        case ($urandom_range(0, 9))
            0: smp = -8'sd128;
            1: smp = 8'sd127;
            default: smp = SAMPLE_W'($urandom);
        endcase
        feed_item(KIND_SAMPLE, INDEX_W'($urandom), COEF_W'($urandom), smp, 1'b0, '0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FRAME_LENGTH:   cfg_len    = val & 16'h1FFF;
            REG_SMOOTH_ENABLE:  cfg_smooth = val & 1;
            REG_AVERAGE_LENGTH: cfg_avg    = val & 16'h007F;
            REG_SHOT_COUNT:     cfg_shot   = val & 16'hFFFF;
            REG_TOMO_COUNT:     cfg_tomo   = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input int len, input int smooth, input int avg,
                               input int shot, input int tomo);
        settle();
        write_reg(REG_FRAME_LENGTH, len);
        write_reg(REG_SMOOTH_ENABLE, smooth);
        write_reg(REG_AVERAGE_LENGTH, avg);
        write_reg(REG_SHOT_COUNT, shot);
        write_reg(REG_TOMO_COUNT, tomo);
        n_setups++;
    endtask

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 27);

    always @(posedge clk)
    begin
        frame_res_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            n_results++;
            if (frame_q.size() == 0)
            begin
                $error("frame result with no expectation waiting");
                errors++;
            end
            else
            begin
                want = frame_q.pop_front();
                if (frame_sum !== want.sum)
                begin
                    $error("frame_sum: expected %0d, got %0d", want.sum, frame_sum);
                    errors++;
                end
                if (is_tomo_frame !== want.tomo)
                begin
                    $error("is_tomo_frame: expected %0d, got %0d", want.tomo, is_tomo_frame);
                    errors++;
                end
                if (frame_number !== want.number)
                begin
                    $error("frame_number: expected %0d, got %0d", want.number, frame_number);
                    errors++;
                end
                if (last_frame !== want.last)
                begin
                    $error("last_frame: expected %0d, got %0d", want.last, last_frame);
                    errors++;
                end
                if (want.last)
                    n_last++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int flen;
        int alen;
        int shot;
        int tomo;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        kind       = KIND_COEF;
        coef_index = '0;
        coef_value = '0;
        sample     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_LEN; r++)
        begin
            case (PLAN[r].op)
                ROW_REG:
                begin
                    settle();
                    write_reg(CFG_IDX_W'(PLAN[r].addr), PLAN[r].data);
                end
                ROW_COEF:
                    feed_item(KIND_COEF, INDEX_W'(PLAN[r].addr), COEF_W'(PLAN[r].data),
                              SAMPLE_W'($urandom), 1'b0, '0);
                default:
                    feed_item(KIND_SAMPLE, INDEX_W'($urandom), COEF_W'($urandom),
                              SAMPLE_W'(PLAN[r].data), PLAN[r].typed, PLAN[r].want);
            endcase
        end

        // Every window position that a random frame can reach gets a
        // coefficient first.
        for (int i = 0; i < PRELOAD_LEN; i++)
            feed_item(KIND_COEF, INDEX_W'(i), COEF_W'($urandom), SAMPLE_W'($urandom),
                      1'b0, '0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0: flen = 0;
                1: flen = 1;
                7, 8: flen = $urandom_range(9, 40);
                9: flen = $urandom_range(41, 200);
                default: flen = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 7))
                0: alen = 0;
                1: alen = MAX_AVERAGE_DEF;
                2: alen = $urandom_range(65, 127);
                default: alen = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 5))
                0:
                begin
                    shot = 0;
                    tomo = 0;
                end
                1:
                begin
                    shot = 65535;
                    tomo = 65535;
                end
                default:
                begin
                    shot = $urandom_range(0, frame_cnt + 2);
                    tomo = frame_cnt + $urandom_range(2, 8) - shot;
                end
            endcase
            apply_setup(flen, $urandom_range(0, 1), alen, shot, tomo);
            calm = (ph == 5 || ph == 6);
            // The phase runs on to a frame boundary so that the next average
            // length never takes effect in mid-frame.
            for (int n = 0; n < PHASE_ITEMS || pos != 0; n++)
            begin
                if (n < PHASE_ITEMS && $urandom_range(0, 99) < 15)
                    feed_item(KIND_COEF, INDEX_W'($urandom), COEF_W'($urandom),
                              SAMPLE_W'($urandom), 1'b0, '0);
                else
                    feed_random_sample();
            end
            calm = 1'b0;
        end

        settle();
        $display("Run covered %0d items (%0d samples, %0d coefficient loads) over %0d setups.",
                 n_items, n_samples, n_items - n_samples, n_setups);
        $display("It checked %0d frame results, %0d of them flagged as the last frame.",
                 n_results, n_last);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
